// ----- rtl/lfbb_pkg.sv -----
// Shared constants, codes and types for the LED frame buffer with brightness.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lfbb_pkg;

	// Store sizing: no request ever returns more than sixteen words
	localparam int LED_CAPACITY = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int ACTIVE_MAX   = (LED_CAPACITY < RESULT_LIMIT) ? LED_CAPACITY : RESULT_LIMIT;
	localparam int IDX_W        = (ACTIVE_MAX > 1) ? $clog2(ACTIVE_MAX) : 1;
	localparam int CNT_W        = 5;
	localparam int LED_INDEX_W  = 8;
	localparam int CHAN_W       = 8;
	localparam int RGB_W        = 3 * CHAN_W;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Request kinds
	localparam logic [1:0] REQ_WRITE_ONE = 2'd0;
	localparam logic [1:0] REQ_WRITE_ALL = 2'd1;
	localparam logic [1:0] REQ_READ_ONE  = 2'd2;
	localparam logic [1:0] REQ_REFRESH   = 2'd3;

	// Configuration register indexes and reset values
	localparam logic [1:0] REG_NUM_LEDS   = 2'd0;
	localparam logic [1:0] REG_BRIGHTNESS = 2'd1;
	localparam logic [1:0] REG_LEDS_ON    = 2'd2;

	localparam logic [CNT_W-1:0]  NUM_LEDS_RST   = 5'd1;
	localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd25;
	localparam logic              LEDS_ON_RST    = 1'b0;

	// Classified request handed from front to back
	typedef struct packed {
		logic [1:0]       req;
		logic             err;
		logic [IDX_W-1:0] idx;
		logic [RGB_W-1:0] rgb;
	} cmd_t;

	// Live configuration seen by the back
	typedef struct packed {
		logic [CNT_W-1:0]  active_n;
		logic [CHAN_W-1:0] brightness;
		logic              leds_on;
	} cfg_t;

endpackage

// ----- rtl/lfbb_front.sv -----
// Front part: configuration registers, input word acceptance and request classification.
// Depends on lfbb_pkg.
module lfbb_front import lfbb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [CHAN_W-1:0]      cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             in_req,
	input  logic [LED_INDEX_W-1:0] in_led_index,
	input  logic [RGB_W-1:0]       in_rgb,
	input  logic                   q_full,
	output logic                   q_push,
	output cmd_t                   q_cmd,
	output cfg_t                   cfg
);

	localparam logic [CNT_W-1:0] ACTIVE_MAX_C = CNT_W'(ACTIVE_MAX);

	logic [CNT_W-1:0]  num_leds_q;
	logic [CHAN_W-1:0] brightness_q;
	logic              leds_on_q;
	logic [CNT_W-1:0]  active_n;
	logic              idx_bad;

	// Take configuration words at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_leds_q   <= NUM_LEDS_RST;
			brightness_q <= BRIGHTNESS_RST;
			leds_on_q    <= LEDS_ON_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_LEDS:   num_leds_q   <= cfg_data[CNT_W-1:0];
				REG_BRIGHTNESS: brightness_q <= cfg_data;
				REG_LEDS_ON:    leds_on_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Limit the active count to what the store holds
	assign active_n = (num_leds_q > ACTIVE_MAX_C) ? ACTIVE_MAX_C : num_leds_q;

	assign cfg.active_n   = active_n;
	assign cfg.brightness = brightness_q;
	assign cfg.leds_on    = leds_on_q;

	// Flag single-LED requests that point past the active chain
	assign idx_bad = in_led_index >= {{(LED_INDEX_W-CNT_W){1'b0}}, active_n};

	// Push classified words into the queue while it has room
	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;
	assign q_cmd.req = in_req;
	assign q_cmd.err = idx_bad && ((in_req == REQ_WRITE_ONE) || (in_req == REQ_READ_ONE));
	assign q_cmd.idx = in_led_index[IDX_W-1:0];
	assign q_cmd.rgb = in_rgb;

endmodule

// ----- rtl/lfbb_queue.sv -----
// Short command queue that decouples the front from the back.
// Depends on lfbb_pkg for the command type and depth.
module lfbb_queue import lfbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/lfbb_back.sv -----
// Back part: colour store, request execution, brightness scaling and output register.
// Depends on lfbb_pkg.
module lfbb_back import lfbb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_status,
	output logic              out_frame,
	output logic [RGB_W-1:0]  out_rgb,
	output logic [RGB_W-1:0]  out_grb,
	output logic              out_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  pos_q;
	logic [RGB_W-1:0]  store_q [ACTIVE_MAX];
	logic [15:0]       prod_red_s1;
	logic [15:0]       prod_green_s1;
	logic [15:0]       prod_blue_s1;
	logic              out_valid_q;
	logic              out_status_q;
	logic              out_frame_q;
	logic [RGB_W-1:0]  out_rgb_q;
	logic [RGB_W-1:0]  out_grb_q;
	logic              out_last_q;
	logic              out_free;
	logic [IDX_W-1:0]  rd_addr;
	logic [RGB_W-1:0]  rd_data;
	logic              word_last;
	logic [RGB_W-1:0]  scaled_grb;

	// Divide a channel product by 255: estimate, then one correction step
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
		logic [16:0]       sum;
		logic [CHAN_W-1:0] q;
		logic [15:0]       r;
		sum = {1'b0, p} + {9'd0, p[15:8]};
		q   = sum[15:8];
		r   = p - ({q, 8'd0} - {8'd0, q});
		if (r >= 16'd255) begin
			q = q + 8'd1;
		end
		return q;
	endfunction

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign rd_addr   = (state_q == ST_IDLE) ? cmd.idx : pos_q[IDX_W-1:0];
	assign rd_data   = store_q[rd_addr];
	assign word_last = (pos_q + CNT_W'(1)) == cfg.active_n;

	assign scaled_grb = cfg.leds_on ? {div255(prod_green_s1), div255(prod_red_s1),
	                                   div255(prod_blue_s1)} : '0;

	// Sequence requests; refresh walks the active LEDs one word at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd.req == REQ_REFRESH) && (cfg.active_n != '0)) begin
						pos_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (out_free) begin
						if (word_last) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + CNT_W'(1);
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Update the colour store; cleared to off at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE_MAX; i++) begin
				store_q[i] <= '0;
			end
		end else if (cmd_pop) begin
			if ((cmd.req == REQ_WRITE_ONE) && !cmd.err) begin
				store_q[cmd.idx] <= cmd.rgb;
			end else if (cmd.req == REQ_WRITE_ALL) begin
				for (int i = 0; i < ACTIVE_MAX; i++) begin
					if (CNT_W'(i) < cfg.active_n) begin
						store_q[i] <= cmd.rgb;
					end
				end
			end
		end
	end

	// Multiply each stored channel by the brightness
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_red_s1   <= {8'd0, rd_data[23:16]} * {8'd0, cfg.brightness};
			prod_green_s1 <= {8'd0, rd_data[15:8]}  * {8'd0, cfg.brightness};
			prod_blue_s1  <= {8'd0, rd_data[7:0]}   * {8'd0, cfg.brightness};
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd_pop && !((cmd.req == REQ_REFRESH) && (cfg.active_n == '0) ||
		                           (cmd.req == REQ_REFRESH))) ||
		             ((state_q == ST_DIV) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.req != REQ_REFRESH)) begin
			out_status_q <= cmd.err;
			out_frame_q  <= 1'b0;
			out_rgb_q    <= ((cmd.req == REQ_READ_ONE) && !cmd.err) ? rd_data : '0;
			out_grb_q    <= '0;
			out_last_q   <= 1'b1;
		end else if ((state_q == ST_DIV) && out_free) begin
			out_status_q <= 1'b0;
			out_frame_q  <= 1'b1;
			out_rgb_q    <= '0;
			out_grb_q    <= scaled_grb;
			out_last_q   <= word_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_frame  = out_frame_q;
	assign out_rgb    = out_rgb_q;
	assign out_grb    = out_grb_q;
	assign out_last   = out_last_q;

endmodule

// ----- rtl/led_frame_buffer_brightness_top.sv -----
// LED frame buffer with brightness: top level tying front, queue and back together.
// Depends on lfbb_pkg, lfbb_front, lfbb_queue and lfbb_back.
//
// Usage:
//   s_* channel takes request words: tuser carries the request kind (write one,
//   write all, read one, refresh), tdata the LED index and color.
//   m_* channel returns result words: tuser marks a refresh frame word, tlast
//   the final word of a request, tdata the status, raw color and GRB word.
//   cfg_* channel writes num_leds, brightness and leds_on; always ready.
// Flow: with the back idle, a write one, write all or read one returns its
//   single word from the output register, and such requests go one per cycle
//   while the receiver takes each word. A refresh of n active LEDs returns n words
//   one at a time, each passing the multiply stage and then the divide-by-255
//   stage before the output register.
// A two-entry command queue lets new requests enter while the back is busy
//   or a result waits to be taken.
// Reset clears every stored color to off, sets num_leds 1, brightness 25 and
//   leds_on 0, and empties the queue.
// When the receiver stalls, the output word holds, the back stops, and input
//   stops once the queue is full; nothing is dropped.
module led_frame_buffer_brightness_top import lfbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // led_index, red, green, blue
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // status, read_red, read_green, read_blue, grb_word, zero pad
	output logic        m_tuser,   // is_frame_word
	output logic        m_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t             cfg;
	cmd_t             push_cmd;
	cmd_t             head_cmd;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_not_empty;
	logic             out_status;
	logic [RGB_W-1:0] out_rgb;
	logic [RGB_W-1:0] out_grb;

	lfbb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_req       (s_tuser),
		.in_led_index (s_tdata[7:0]),
		.in_rgb       ({s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.cfg          (cfg)
	);

	lfbb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_cmd)
	);

	lfbb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd_valid  (q_not_empty),
		.cmd        (head_cmd),
		.cmd_pop    (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_frame  (m_tuser),
		.out_rgb    (out_rgb),
		.out_grb    (out_grb),
		.out_last   (m_tlast)
	);

	// Pack result fields from the lowest bit up
	assign m_tdata = {7'd0, out_grb, out_rgb[7:0], out_rgb[15:8], out_rgb[23:16], out_status};

endmodule
